[rtl/cop_pkg.sv]
// ----------------------------------------------------------------------------
// cop_pkg: shared types and constants of the circle outline pixel generator
// Holds the beat layouts of both channels, the operation codes, the pixel
// group kinds and the constants of the midpoint decision update.
// ----------------------------------------------------------------------------
package cop_pkg;

    // Width of a pixel coordinate. Sums wrap at this width.
    localparam int COORD_BITS = 16;
    // Width of the signed decision value.
    localparam int DEC_BITS   = COORD_BITS + 6;
    localparam int COLOR_BITS = 32;

    // Most results that one input beat can cause, and the index width.
    localparam int MAX_RESULTS = 8;
    localparam int IDX_BITS    = $clog2(MAX_RESULTS);

    // Midpoint decision constants.
    localparam int DEC_INIT     = 3;
    localparam int DEC_INC_KEEP = 6;
    localparam int DEC_INC_STEP = 10;

    // Operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Kind of pixel group that one input beat produces.
    typedef enum logic [1:0] {
        K_MARK,   // a single marker result, no pixel
        K_AXIS,   // the four axis points of a new circle
        K_OCT,    // eight octant points
        K_DIAG    // the four diagonal points that end a circle
    } t_kind;

    typedef struct packed {
        logic                  operation;
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [COORD_BITS-1:0] radius;
        logic [COLOR_BITS-1:0] color;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  is_pixel;
        logic                  last_of_item;
        logic                  circle_done;
    } t_out_item;

endpackage

[rtl/circle_outline_pixel_generator.sv]
// ----------------------------------------------------------------------------
// circle_outline_pixel_generator: midpoint circle outline pixel source
// Turns start and step beats into the outline pixels of a circle, one pixel
// beat per cycle on the output channel while it is not stalled.
// ----------------------------------------------------------------------------
// A start beat (operation 0) latches centre, radius and color and yields the
// four axis points; every step beat (operation 1) then yields the next group
// of eight octant points, or the four diagonal points that finish the circle.
// A start with radius zero, or a step while no circle is in progress, yields
// one marker beat with is_pixel low and circle_done high. The output channel
// carries one result beat per cycle while it is not stalled, so an input beat
// occupies the block until its last result moves into the output register,
// and a circle of radius r takes about 0.7*r step beats. The next input beat
// is taken in the same cycle that the last pixel of the current group moves
// into the output register, so groups follow each other without a gap while
// the consumer keeps up. Coordinates wrap modulo 2^16. A start beat accepted
// while a circle is in progress abandons that circle.
// ----------------------------------------------------------------------------
module circle_outline_pixel_generator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  cop_pkg::t_in_item     i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output cop_pkg::t_out_item    o_out_beat
);

    localparam int CW = cop_pkg::COORD_BITS;
    localparam int DW = cop_pkg::DEC_BITS;
    localparam int IW = cop_pkg::IDX_BITS;

    // Circle state: what the next step beat works from.
    logic [CW-1:0]                  r_cx, r_cy, n_cx, n_cy;
    logic [cop_pkg::COLOR_BITS-1:0] r_color, n_color;
    logic [CW-1:0]                  r_x, r_y, n_x, n_y;
    logic signed [DW-1:0]           r_dec, n_dec;
    logic                           r_busy, n_busy;

    // Group register: one accepted beat's pixel group, walked by r_idx.
    logic                           r_grp_valid;
    cop_pkg::t_kind                 r_grp_kind, n_grp_kind;
    logic [CW-1:0]                  r_grp_cx, r_grp_cy;
    logic [cop_pkg::COLOR_BITS-1:0] r_grp_color;
    logic [CW-1:0]                  r_grp_a, r_grp_b, n_grp_a, n_grp_b;
    logic [IW-1:0]                  r_idx;

    // Output register.
    logic                           r_out_valid;
    cop_pkg::t_out_item             r_out, n_out;

    logic in_acc;
    logic grp_adv;
    logic grp_last;

    // The group moves one pixel into the output register whenever that
    // register is empty or is being emptied in this cycle.
    assign grp_adv    = r_grp_valid && (!r_out_valid || !i_out_stall);
    // A new beat may enter once the group register frees up in this cycle.
    assign o_in_stall = r_grp_valid && !(grp_adv && grp_last);
    assign in_acc     = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Circle state update and group setup for the incoming beat.
    // ------------------------------------------------------------------
    always_comb begin
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_color    = r_color;
        n_x        = r_x;
        n_y        = r_y;
        n_dec      = r_dec;
        n_busy     = r_busy;
        n_grp_kind = cop_pkg::K_MARK;
        n_grp_a    = '0;
        n_grp_b    = '0;
        if (i_in_beat.operation == cop_pkg::OP_START) begin
            n_cx    = i_in_beat.center_x;
            n_cy    = i_in_beat.center_y;
            n_color = i_in_beat.color;
            if (i_in_beat.radius == '0) begin
                n_busy = 1'b0;
            end else begin
                n_busy     = 1'b1;
                n_x        = CW'(1);
                n_y        = i_in_beat.radius;
                n_dec      = DW'(cop_pkg::DEC_INIT) - (DW'(i_in_beat.radius) << 1);
                n_grp_kind = cop_pkg::K_AXIS;
                n_grp_a    = i_in_beat.radius;
            end
        end else if (r_busy) begin
            if (r_x < r_y) begin
                n_grp_kind = cop_pkg::K_OCT;
                n_grp_a    = r_x;
                n_grp_b    = r_y;
                if (r_dec[DW-1]) begin
                    n_dec = r_dec + (DW'(r_x) << 2) + DW'(cop_pkg::DEC_INC_KEEP);
                end else begin
                    n_dec = r_dec + ((DW'(r_x) - DW'(r_y)) << 2)
                          + DW'(cop_pkg::DEC_INC_STEP);
                    n_y   = r_y - CW'(1);
                end
                n_x = r_x + CW'(1);
            end else begin
                n_grp_kind = cop_pkg::K_DIAG;
                n_grp_a    = r_y;
                n_busy     = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel selection for the current index of the group.
    // In an octant group the upper half swaps the roles of x and y; the
    // sign pattern over the low two index bits is ++, +-, --, -+.
    // ------------------------------------------------------------------
    logic [CW-1:0] e_dx, e_dy;
    logic          e_negx, e_negy, e_pix, e_done;

    always_comb begin
        e_dx     = r_grp_a;
        e_dy     = r_grp_a;
        e_negx   = r_idx[1];
        e_negy   = r_idx[1] ^ r_idx[0];
        e_pix    = 1'b1;
        e_done   = 1'b0;
        grp_last = (r_idx[1:0] == 2'b11);
        case (r_grp_kind)
            cop_pkg::K_MARK: begin
                e_dx     = '0;
                e_dy     = '0;
                e_negx   = 1'b0;
                e_negy   = 1'b0;
                e_pix    = 1'b0;
                e_done   = 1'b1;
                grp_last = 1'b1;
            end
            cop_pkg::K_AXIS: begin
                // Points (0,+r), (0,-r), (+r,0), (-r,0).
                e_dx   = r_idx[1] ? r_grp_a : '0;
                e_dy   = r_idx[1] ? '0 : r_grp_a;
                e_negx = r_idx[1] & r_idx[0];
                e_negy = !r_idx[1] & r_idx[0];
            end
            cop_pkg::K_OCT: begin
                e_dx     = r_idx[2] ? r_grp_b : r_grp_a;
                e_dy     = r_idx[2] ? r_grp_a : r_grp_b;
                grp_last = (r_idx == IW'(cop_pkg::MAX_RESULTS - 1));
            end
            cop_pkg::K_DIAG: begin
                e_done = grp_last;
            end
            default: begin
                e_pix = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out.pixel_x      = '0;
        n_out.pixel_y      = '0;
        if (e_pix) begin
            n_out.pixel_x = e_negx ? (r_grp_cx - e_dx) : (r_grp_cx + e_dx);
            n_out.pixel_y = e_negy ? (r_grp_cy - e_dy) : (r_grp_cy + e_dy);
        end
        n_out.pixel_color  = r_grp_color;
        n_out.is_pixel     = e_pix;
        n_out.last_of_item = grp_last;
        n_out.circle_done  = e_done;
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx        <= '0;
            r_cy        <= '0;
            r_color     <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_dec       <= '0;
            r_busy      <= 1'b0;
            r_grp_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_cx        <= n_cx;
                r_cy        <= n_cy;
                r_color     <= n_color;
                r_x         <= n_x;
                r_y         <= n_y;
                r_dec       <= n_dec;
                r_busy      <= n_busy;
                r_grp_valid <= 1'b1;
                r_idx       <= '0;
            end else if (grp_adv) begin
                if (grp_last) begin
                    r_grp_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            if (grp_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_grp_kind  <= n_grp_kind;
            r_grp_cx    <= n_cx;
            r_grp_cy    <= n_cy;
            r_grp_color <= n_color;
            r_grp_a     <= n_grp_a;
            r_grp_b     <= n_grp_b;
        end
        if (grp_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

[rtl/cop_checker.sv]
// ----------------------------------------------------------------------------
// cop_checker: port-level checks of the circle outline pixel generator
// Watches the output channel for marker and end-of-circle consistency and
// for correct behavior around reset.
// ----------------------------------------------------------------------------
module cop_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  cop_pkg::t_out_item i_out_beat
);

    // A marker beat always closes its input beat and reports the block idle.
    a_marker_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_beat.is_pixel) |->
            (i_out_beat.last_of_item && i_out_beat.circle_done))
        else $error("marker beat without last_of_item or circle_done");

    // A marker beat carries zero coordinates.
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_beat.is_pixel) |->
            (i_out_beat.pixel_x == '0 && i_out_beat.pixel_y == '0))
        else $error("marker beat with nonzero coordinates");

    // The circle can only finish on the final beat of an input beat.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_beat.circle_done) |-> i_out_beat.last_of_item)
        else $error("circle_done set on a beat that is not last");

    // Nothing is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // A stalled output beat holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_out_beat)))
        else $error("stalled output beat changed");

endmodule

bind circle_outline_pixel_generator cop_checker u_cop_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_beat  (o_out_beat)
);
